>>> rtl/amb_pkg.sv
// Shared types and codes for the adjacency-matrix graph search block.
// Used by the controller, the datapath and the top level.
package amb_pkg;

    // Input item mode codes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_BFS = 2'd1;
    localparam logic [1:0] MODE_DFS = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_INIT,
        S_POP,
        S_ROW,
        S_SCAN,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic add_write;
        logic init;
        logic pop;
        logic row_load;
        logic scan_step;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic in_add_ok;
        logic in_search;
        logic start_out;
        logic cand_none;
        logic dfs;
        logic count_zero;
        logic out_free;
    } t_status;

endpackage

>>> rtl/amb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module amb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/amb_ctrl.sv
// Sequencing state machine for the graph search block.
// Depends on amb_pkg; drives commands to amb_dp and reads its status.
module amb_ctrl
    import amb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && i_status.in_add_ok) n_state = S_ADD_RD;
                else if (i_valid && i_status.in_search) n_state = S_INIT;
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: n_state = S_IDLE;
            S_INIT: begin
                n_state = i_status.start_out ? S_EMIT : S_POP;
            end
            S_POP:  n_state = S_ROW;
            S_ROW:  n_state = S_SCAN;
            S_SCAN: begin
                if (i_status.cand_none || i_status.dfs) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.count_zero ? S_IDLE : S_POP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_step = 1'b1;
            S_IDLE:   o_cmd.accept = i_valid;
            S_ADD_RD: o_cmd = '0;
            S_ADD_WR: o_cmd.add_write = 1'b1;
            S_INIT:   o_cmd.init = 1'b1;
            S_POP:    o_cmd.pop = 1'b1;
            S_ROW:    o_cmd.row_load = 1'b1;
            S_SCAN:   o_cmd.scan_step = !i_status.cand_none;
            S_EMIT:   o_cmd.emit = i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // Clearing pass runs only once after reset
    a_no_reclear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass re-entered");
    // Items are taken only when the block is idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> (r_state == S_IDLE))
        else $error("item taken outside idle");
    // Emit never happens with the output register full and stalled
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result overwritten");
`endif

endmodule

>>> rtl/amb_dp.sv
// Datapath: weight matrix, adjacency bits, visit state, queue/stack, result register.
// Depends on amb_pkg and amb_ram; steered by amb_ctrl.
module amb_dp
    import amb_pkg::*;
#(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_from_node,
    input  logic [3:0]  i_to_node,
    input  logic        i_target_valid,
    input  logic signed [15:0] i_weight,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    input  logic        i_stall,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_valid,
    output logic [3:0]  o_node,
    output logic [3:0]  o_hops,
    output logic [3:0]  o_parent,
    output logic        o_parent_valid,
    output logic        o_found,
    output logic        o_last
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int CELLS = MAX_NODES * MAX_NODES;
    localparam int WAW   = $clog2(CELLS);
    localparam int SW    = ((WEIGHT_BITS > 16) ? WEIGHT_BITS : 16) + 2;
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (WEIGHT_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    // Registers
    logic [4:0]           r_node_count;
    logic [WAW-1:0]       r_clr;
    logic                 r_dfs;
    logic [3:0]           r_a;
    logic [3:0]           r_b;
    logic                 r_tv;
    logic signed [15:0]   r_w;
    logic [NW-1:0]        r_cur;
    logic                 r_start_out;
    logic                 r_found;
    logic [MAX_NODES-1:0] r_visited;
    logic [MAX_NODES-1:0] r_row;
    logic [3:0]           r_hop  [MAX_NODES];
    logic [NW-1:0]        r_par  [MAX_NODES];
    logic [NW-1:0]        r_list [MAX_NODES];
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_head;
    logic                 r_o_valid;

    // Combinational
    logic [MAX_NODES-1:0]   nmask;
    logic [MAX_NODES-1:0]   cand;
    logic [NW-1:0]          pick;
    logic [NW-1:0]          next_cur;
    logic                   start_out;
    logic                   is_start;
    logic [WAW-1:0]         cell_addr;
    logic signed [WEIGHT_BITS-1:0] wt_rdata;
    logic signed [WEIGHT_BITS-1:0] wt_wdata;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   sat;
    logic [MAX_NODES-1:0]   adj_rdata;
    logic [MAX_NODES-1:0]   adj_wdata;
    logic [MAX_NODES-1:0]   new_row;
    logic                   adj_we;
    logic [NW-1:0]          adj_waddr;
    logic [NW-1:0]          adj_raddr;
    logic [WAW-1:0]         wt_waddr;
    logic                   out_free;

    // Active node mask from the clamped node count
    always_comb begin
        int n;
        n = int'(r_node_count);
        if (n == 0) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        for (int k = 0; k < MAX_NODES; k++) begin
            nmask[k] = (k < n);
        end
        start_out = (int'(r_a) >= n);
    end

    // Lowest unvisited neighbour of the current row
    assign cand = r_row & ~r_visited & nmask;
    always_comb begin
        pick = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--) begin
            if (cand[k]) pick = NW'(k);
        end
    end

    assign next_cur = r_dfs ? r_list[NW'(r_count - CW'(1))] : r_list[NW'(r_head)];
    assign is_start = r_start_out || (r_cur == NW'(r_a));

    // Saturating add of the weight into the addressed cell
    assign cell_addr = WAW'(int'(r_a) * MAX_NODES + int'(r_b));
    assign sum = SW'(wt_rdata) + SW'(r_w);
    always_comb begin
        if (sum > MAXV) sat = MAXV;
        else if (sum < MINV) sat = MINV;
        else sat = sum;
        new_row = adj_rdata;
        new_row[NW'(r_b)] = (sat != '0);
    end

    // Memory port steering
    assign wt_waddr  = i_cmd.clr_step ? r_clr : cell_addr;
    assign wt_wdata  = i_cmd.clr_step ? '0 : WEIGHT_BITS'(sat);
    assign adj_we    = (i_cmd.clr_step && (int'(r_clr) < MAX_NODES)) || i_cmd.add_write;
    assign adj_waddr = i_cmd.clr_step ? NW'(r_clr) : NW'(r_a);
    assign adj_wdata = i_cmd.clr_step ? '0 : new_row;
    assign adj_raddr = i_cmd.pop ? next_cur : NW'(r_a);

    amb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CELLS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_step || i_cmd.add_write),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (cell_addr),
        .o_rdata (wt_rdata)
    );

    amb_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 5'd16;
            r_clr        <= '0;
            r_count      <= '0;
            r_head       <= '0;
        end else begin
            if (i_cfg_wr_en) r_node_count <= i_cfg_wr_data;
            if (i_cmd.clr_step) r_clr <= r_clr + WAW'(1);
            if (i_cmd.init) begin
                r_count <= start_out ? CW'(0) : CW'(1);
                r_head  <= '0;
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                if (!r_dfs) r_head <= r_head + CW'(1);
            end else if (i_cmd.scan_step) begin
                r_count <= r_count + (r_dfs ? CW'(2) : CW'(1));
            end
        end
    end

    // Item latch and search state
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dfs <= (i_mode == MODE_DFS);
            r_a   <= i_from_node;
            r_b   <= i_to_node;
            r_tv  <= i_target_valid;
            r_w   <= i_weight;
        end
        if (i_cmd.init) begin
            r_cur       <= NW'(r_a);
            r_start_out <= start_out;
            r_found     <= r_tv && (r_a == r_b);
            // clear all visit flags; mark the start node unless it is outside the count
            r_visited   <= start_out ? '0 : (MAX_NODES'(1) << r_a);
            if (!start_out) begin
                r_hop[NW'(r_a)]     <= '0;
                r_par[NW'(r_a)]     <= '0;
                r_list[0]           <= NW'(r_a);
            end
        end
        if (i_cmd.pop) r_cur <= next_cur;
        if (i_cmd.row_load) r_row <= adj_rdata;
        if (i_cmd.scan_step) begin
            r_visited[pick] <= 1'b1;
            r_hop[pick]     <= r_hop[r_cur] + 4'd1;
            r_par[pick]     <= r_cur;
            if (r_tv && (int'(pick) == int'(r_b))) r_found <= 1'b1;
            if (r_dfs) begin
                r_list[NW'(r_count)]          <= r_cur;
                r_list[NW'(r_count + CW'(1))] <= pick;
            end else begin
                r_list[NW'(r_head + r_count)] <= pick;
            end
        end
    end

    // Result register: load on emit, drop once taken
    assign out_free = !r_o_valid || !i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_node         <= r_start_out ? r_a : 4'(r_cur);
            o_hops         <= is_start ? 4'd0 : r_hop[r_cur];
            o_parent       <= is_start ? 4'd0 : 4'(r_par[r_cur]);
            o_parent_valid <= !is_start;
            o_last         <= (r_count == '0);
            o_found        <= (r_count == '0) && r_found;
        end
    end

    assign o_valid = r_o_valid;

    // Status
    always_comb begin
        o_status            = '0;
        o_status.clr_done   = (r_clr == WAW'(CELLS - 1));
        o_status.in_add_ok  = (i_mode == MODE_ADD) && (int'(i_from_node) < MAX_NODES)
                              && (int'(i_to_node) < MAX_NODES);
        o_status.in_search  = (i_mode == MODE_BFS) || (i_mode == MODE_DFS);
        o_status.start_out  = start_out;
        o_status.cand_none  = (cand == '0);
        o_status.dfs        = r_dfs;
        o_status.count_zero = (r_count == '0);
        o_status.out_free   = out_free;
    end

`ifndef SYNTHESIS
    // Pending list never outgrows MAX_NODES entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_NODES)
        else $error("pending list overflow");
    // Found shows only on the final result
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !o_found)
        else $error("found on non-final result");
    // Every emitted node inside the count has been visited
    a_emit_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_start_out) |-> r_visited[r_cur])
        else $error("unvisited node emitted");
`endif

endmodule

>>> rtl/adjacency_matrix_bfs_dfs.sv
// Dense-graph search engine, one item at a time: an add item steps through accept, read
// and write, with no result. Search: set-up (accept, init), then pop, row read, scan and
// emit per dequeue/pop, with a scan step for each node found in a breadth-first row; a
// stalled result holds emit. Depth-first pops 2k-1 times for k nodes; a start outside the
// count goes from init straight to a single emit. Reset (synchronous, active low) runs a
// clearing pass over the weight and adjacency RAMs before the first item is taken.
module adjacency_matrix_bfs_dfs
    import amb_pkg::*;
#(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_from_node,
    input  logic [3:0]  i_to_node,
    input  logic        i_target_valid,
    input  logic signed [15:0] i_weight,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_node,
    output logic [3:0]  o_hops,
    output logic [3:0]  o_parent,
    output logic        o_parent_valid,
    output logic        o_found,
    output logic        o_last
);

    t_cmd    cmd;
    t_status status;

    amb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    amb_dp #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .i_target_valid (i_target_valid),
        .i_weight       (i_weight),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_node         (o_node),
        .o_hops         (o_hops),
        .o_parent       (o_parent),
        .o_parent_valid (o_parent_valid),
        .o_found        (o_found),
        .o_last         (o_last)
    );

endmodule
